// ----- rtl/tsc_pkg.sv -----
package tsc_pkg;

    // field widths
    localparam int COORD_W = 12;
    localparam int TIMER_W = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // shared multiplier: a is one or two coordinates wide, b one coordinate
    localparam int MUL_A_W = 2 * COORD_W;
    localparam int MUL_P_W = MUL_A_W + COORD_W;

    // shared divider: dividend register and step counter
    localparam int DIV_W   = MUL_P_W;
    localparam int CNT_W   = $clog2(DIV_W + 1);

    // pressure rounding and output range
    localparam logic [DIV_W:0]   PR_ROUND = (DIV_W + 1)'(2047);
    localparam int               PR_SHIFT = 12;
    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

    // register indexes
    localparam logic [IDX_W-1:0] CFG_CAL_X_MIN    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CAL_X_MAX    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CAL_Y_MIN    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CAL_Y_MAX    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PLATE_OHMS   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_JITTER_LIMIT = 3'd5;
    localparam logic [IDX_W-1:0] CFG_PENUP_TICKS  = 3'd6;

    // input mode and result kind codes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;
    localparam logic KIND_POS    = 1'b0;
    localparam logic KIND_REL    = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
        logic [COORD_W-1:0] raw_z1;
        logic [COORD_W-1:0] raw_z2;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pressure;
        logic               touch_start;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MULX,
        S_DIVX,
        S_MULY,
        S_DIVY,
        S_FIXY,
        S_MULP1,
        S_MULP2,
        S_DIVP,
        S_CHECK,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/tsc_in_if.sv -----
interface tsc_in_if;
    import tsc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tsc_out_if.sv -----
interface tsc_out_if;
    import tsc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/touch_sample_conditioner_unit.sv -----
// Touch sample: scaled by the shared restoring divider (24 + 24 + 36 one-bit steps) behind
// one multiplier. Time tick: counts down the armed pen-up timer and makes a release report
// when it runs out. A finished result waits in the output register while the next word is
// taken in; a full one holds the block.
// Synchronous active-low reset: calibration defaults, state clears, countdown disarmed.
module touch_sample_conditioner_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tsc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [tsc_pkg::CFG_W-1:0]   i_cfg_data,
    tsc_in_if.sink                      i_in,
    tsc_out_if.source                   o_out
);
    import tsc_pkg::*;

    // configuration
    logic [COORD_W-1:0] r_cal_x_min, r_cal_x_max, r_cal_y_min, r_cal_y_max;
    logic [COORD_W-1:0] r_plate_ohms, r_jitter_limit;
    logic [TIMER_W-1:0] r_penup_ticks;

    // sequencer and held word
    t_state             r_state, n_state;
    t_in_item           r_item;

    // tracking state
    logic [COORD_W-1:0] r_last_x, r_last_y;
    logic               r_pen_active;
    logic [TIMER_W-1:0] r_countdown;
    logic               r_armed;

    // datapath
    logic [COORD_W-1:0] r_px, r_py;
    logic [MUL_A_W-1:0] r_prod;
    logic [DIV_W-1:0]   r_dq;
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_dvs;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_qneg;
    logic               r_zspan;

    // results
    t_out_item          r_res;
    t_out_item          r_out;
    logic               r_out_vld;

    // combinational
    logic               in_acc;
    logic               out_free;
    logic [MUL_A_W-1:0] mul_a;
    logic [COORD_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [COORD_W:0]   div_sh;
    logic [COORD_W:0]   div_sub;
    logic               div_ge;
    logic [COORD_W:0]   xd_raw, xs_raw, yd_raw, ys_raw;
    logic [COORD_W-1:0] xd_mag, xs_mag, yd_mag, ys_mag;
    logic [COORD_W-1:0] fix_x, fix_y;
    logic [MUL_A_W:0]   y_sum;
    logic [DIV_W:0]     pr_sum;
    logic               pr_bad;
    logic [COORD_W-1:0] jit_dx, jit_dy;
    logic               report;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_x_min    <= '0;
            r_cal_x_max    <= COORD_MAX;
            r_cal_y_min    <= '0;
            r_cal_y_max    <= COORD_MAX;
            r_plate_ohms   <= COORD_W'(400);
            r_jitter_limit <= COORD_W'(15);
            r_penup_ticks  <= TIMER_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAL_X_MIN:    r_cal_x_min    <= i_cfg_data[COORD_W-1:0];
                CFG_CAL_X_MAX:    r_cal_x_max    <= i_cfg_data[COORD_W-1:0];
                CFG_CAL_Y_MIN:    r_cal_y_min    <= i_cfg_data[COORD_W-1:0];
                CFG_CAL_Y_MAX:    r_cal_y_max    <= i_cfg_data[COORD_W-1:0];
                CFG_PLATE_OHMS:   r_plate_ohms   <= i_cfg_data[COORD_W-1:0];
                CFG_JITTER_LIMIT: r_jitter_limit <= i_cfg_data[COORD_W-1:0];
                CFG_PENUP_TICKS:  r_penup_ticks  <= i_cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // signed differences against calibration, kept as sign and magnitude
    always_comb begin
        xd_raw = {1'b0, r_item.raw_x} - {1'b0, r_cal_x_min};
        xs_raw = {1'b0, r_cal_x_max}  - {1'b0, r_cal_x_min};
        yd_raw = {1'b0, r_item.raw_y} - {1'b0, r_cal_y_min};
        ys_raw = {1'b0, r_cal_y_max}  - {1'b0, r_cal_y_min};
        xd_mag = xd_raw[COORD_W] ? COORD_W'(-xd_raw) : xd_raw[COORD_W-1:0];
        xs_mag = xs_raw[COORD_W] ? COORD_W'(-xs_raw) : xs_raw[COORD_W-1:0];
        yd_mag = yd_raw[COORD_W] ? COORD_W'(-yd_raw) : yd_raw[COORD_W-1:0];
        ys_mag = ys_raw[COORD_W] ? COORD_W'(-ys_raw) : ys_raw[COORD_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_DECODE;
            S_DECODE: begin
                if (r_item.mode == MODE_SAMPLE) begin
                    n_state = S_MULX;
                end else if (r_armed && r_countdown <= TIMER_W'(1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MULX:   n_state = S_DIVX;
            S_DIVX:   if (r_cnt == CNT_W'(1)) n_state = S_MULY;
            S_MULY:   n_state = S_DIVY;
            S_DIVY:   if (r_cnt == CNT_W'(1)) n_state = S_FIXY;
            S_FIXY:   n_state = S_MULP1;
            S_MULP1:  n_state = S_MULP2;
            S_MULP2:  n_state = S_DIVP;
            S_DIVP:   if (r_cnt == CNT_W'(1)) n_state = S_CHECK;
            S_CHECK:  n_state = report ? S_EMIT : S_IDLE;
            S_EMIT:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // handshake and shared multiplier operand select
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_MULX: begin
                mul_a = MUL_A_W'(xd_mag);
                mul_b = r_cal_x_max;
            end
            S_MULY: begin
                mul_a = MUL_A_W'(yd_mag);
                mul_b = r_cal_y_max;
            end
            S_MULP1: begin
                mul_a = MUL_A_W'(r_item.raw_z2 - r_item.raw_z1);
                mul_b = r_py;
            end
            S_MULP2: begin
                mul_a = r_prod;
                mul_b = r_plate_ohms;
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // one restoring divider step
    always_comb begin
        div_sh  = {r_rem, r_dq[DIV_W-1]};
        div_ge  = div_sh >= {1'b0, r_dvs};
        div_sub = div_sh - {1'b0, r_dvs};
    end

    // clamp of the coordinate quotients
    always_comb begin
        y_sum = {1'b0, r_dq[MUL_A_W-1:0]} + (MUL_A_W + 1)'(r_cal_y_max);
        if (r_zspan || r_qneg) begin
            fix_x = '0;
        end else if (r_dq[MUL_A_W-1:COORD_W] != '0) begin
            fix_x = COORD_MAX;
        end else begin
            fix_x = r_dq[COORD_W-1:0];
        end
        if (r_zspan) begin
            fix_y = r_cal_y_max;
        end else if (r_qneg) begin
            fix_y = (y_sum[MUL_A_W:COORD_W] != '0) ? COORD_MAX : y_sum[COORD_W-1:0];
        end else if (r_dq[MUL_A_W-1:0] > MUL_A_W'(r_cal_y_max)) begin
            fix_y = '0;
        end else begin
            fix_y = r_cal_y_max - r_dq[COORD_W-1:0];
        end
    end

    // pressure rounding, drop and jitter checks
    always_comb begin
        pr_sum = {1'b0, r_dq} + PR_ROUND;
        pr_bad = (r_item.raw_z1 == '0) || (r_item.raw_z2 < r_item.raw_z1) ||
                 (pr_sum[DIV_W:PR_SHIFT+COORD_W] != '0) ||
                 (pr_sum[DIV_W:PR_SHIFT] == '0);
        jit_dx = (r_px > r_last_x) ? r_px - r_last_x : r_last_x - r_px;
        jit_dy = (r_py > r_last_y) ? r_py - r_last_y : r_last_y - r_py;
        report = !pr_bad && (jit_dx < r_jitter_limit) && (jit_dy < r_jitter_limit);
    end

    // sequencer, divider and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_pen_active <= 1'b0;
            r_countdown  <= '0;
            r_armed      <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (in_acc) r_item <= i_in.data;
                S_DECODE: begin
                    if (r_item.mode == MODE_SAMPLE) begin
                        r_countdown <= r_penup_ticks;
                        r_armed     <= 1'b1;
                    end else if (r_armed) begin
                        if (r_countdown <= TIMER_W'(1)) begin
                            r_countdown  <= '0;
                            r_armed      <= 1'b0;
                            r_pen_active <= 1'b0;
                            r_res        <= '{kind: KIND_REL, pos_x: '0, pos_y: '0,
                                              pressure: '0, touch_start: 1'b0};
                        end else begin
                            r_countdown <= r_countdown - TIMER_W'(1);
                        end
                    end
                end
                S_MULX: begin
                    r_dq    <= {mul_p[MUL_A_W-1:0], COORD_W'(0)};
                    r_rem   <= '0;
                    r_dvs   <= xs_mag;
                    r_cnt   <= CNT_W'(MUL_A_W);
                    r_qneg  <= xd_raw[COORD_W] ^ xs_raw[COORD_W];
                    r_zspan <= (xs_mag == '0);
                end
                S_MULY: begin
                    r_px    <= fix_x;
                    r_dq    <= {mul_p[MUL_A_W-1:0], COORD_W'(0)};
                    r_rem   <= '0;
                    r_dvs   <= ys_mag;
                    r_cnt   <= CNT_W'(MUL_A_W);
                    r_qneg  <= yd_raw[COORD_W] ^ ys_raw[COORD_W];
                    r_zspan <= (ys_mag == '0);
                end
                S_FIXY:  r_py   <= fix_y;
                S_MULP1: r_prod <= mul_p[MUL_A_W-1:0];
                S_MULP2: begin
                    r_dq  <= mul_p;
                    r_rem <= '0;
                    r_dvs <= r_item.raw_z1;
                    r_cnt <= CNT_W'(DIV_W);
                end
                S_DIVX, S_DIVY, S_DIVP: begin
                    r_dq  <= {r_dq[DIV_W-2:0], div_ge};
                    r_rem <= div_ge ? div_sub[COORD_W-1:0] : div_sh[COORD_W-1:0];
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                S_CHECK: begin
                    r_last_x <= r_px;
                    r_last_y <= r_py;
                    if (report) begin
                        r_pen_active <= 1'b1;
                        r_res        <= '{kind: KIND_POS, pos_x: r_px, pos_y: r_py,
                                          pressure: pr_sum[PR_SHIFT+COORD_W-1:PR_SHIFT],
                                          touch_start: !r_pen_active};
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_vld <= 1'b1;
            r_out     <= r_res;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input ready right after an accepted word");

    // divider never idles inside a divide state
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX || r_state == S_DIVY || r_state == S_DIVP) |-> r_cnt != '0)
        else $error("divide state with exhausted step count");

    // pen goes down only on a position report
    a_pen_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pen_active) |-> $past(r_state) == S_CHECK)
        else $error("pen down outside of a report");

endmodule

// ----- tb/tb_touch_sample_conditioner_unit.sv -----
`timescale 1ns / 1ps

module tb_touch_sample_conditioner_unit;
    import tsc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REST_CYCLES   = 120;
    localparam int WORDS_PER_SET = 150;
    localparam logic [IDX_W-1:0] CFG_SPARE = 3'd7;

    // directed table rows
    typedef enum {ROW_CFG, ROW_WORD} t_row_op;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_RELEASE} t_row_chk;

    typedef struct {
        t_row_op          op;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] val;
        t_in_item         word;
        t_row_chk         chk;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    tsc_in_if  smp_if ();
    tsc_out_if rpt_if ();

    touch_sample_conditioner_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (smp_if),
        .o_out      (rpt_if)
    );

    // register shadow and conditioner state
    longint    cfg_shadow [0:6];
    longint    prev_x, prev_y;
    bit        pen_active;
    longint    penup_count;
    bit        penup_armed;

    t_out_item expected_reports [$];
    t_dir_row  dir_rows [$];
    t_row_chk  row_check;
    int        src_gap_pct;
    int        sink_stall_pct;
    int        words_sent;
    int        error_count;
    int        cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // scaling helpers: truncating signed division, clamp to coordinate range
    function automatic longint cal_ratio(longint full, longint raw, longint lo);
        longint span;
        span = full - lo;
        if (span == 0) return 0;
        return (full * (raw - lo)) / span;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v < 0) return 0;
        if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
        return v;
    endfunction

    // predicts the report for one accepted word and advances the state
    function automatic bit condition_sample(input t_in_item w, output t_out_item r);
        longint sx, sy, dx, dy, z1, z2, pr;
        r = '0;
        if (w.mode == MODE_TICK) begin
            if (!penup_armed) return 0;
            if (penup_count <= 1) begin
                penup_count = 0;
                penup_armed = 0;
                pen_active  = 0;
                r.kind      = KIND_REL;
                return 1;
            end
            penup_count = penup_count - 1;
            return 0;
        end

        // any sample reloads the pen-up countdown
        penup_count = cfg_shadow[CFG_PENUP_TICKS];
        penup_armed = 1;

        sx = clamp_coord(cal_ratio(cfg_shadow[CFG_CAL_X_MAX], longint'(w.raw_x),
                                   cfg_shadow[CFG_CAL_X_MIN]));
        sy = clamp_coord(cfg_shadow[CFG_CAL_Y_MAX] -
                         cal_ratio(cfg_shadow[CFG_CAL_Y_MAX], longint'(w.raw_y),
                                   cfg_shadow[CFG_CAL_Y_MIN]));
        dx = (sx > prev_x) ? sx - prev_x : prev_x - sx;
        dy = (sy > prev_y) ? sy - prev_y : prev_y - sy;
        prev_x = sx;
        prev_y = sy;

        z1 = longint'(w.raw_z1);
        z2 = longint'(w.raw_z2);
        if (z1 == 0 || z2 < z1) return 0;
        pr = (z2 - z1) * sy * cfg_shadow[CFG_PLATE_OHMS] / z1;
        pr = (pr + longint'(PR_ROUND)) >> PR_SHIFT;
        if (pr > longint'(COORD_MAX) || pr == 0) return 0;
        if (dx >= cfg_shadow[CFG_JITTER_LIMIT] || dy >= cfg_shadow[CFG_JITTER_LIMIT])
            return 0;

        r.kind        = KIND_POS;
        r.pos_x       = COORD_W'(sx);
        r.pos_y       = COORD_W'(sy);
        r.pressure    = COORD_W'(pr);
        r.touch_start = !pen_active;
        pen_active    = 1;
        return 1;
    endfunction

    function automatic t_dir_row cfg_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_dir_row row;
        row      = '{ROW_CFG, idx, val, '0, CHK_MODEL};
        return row;
    endfunction

    function automatic t_dir_row word_row(logic mode, logic [11:0] x, logic [11:0] y,
                                          logic [11:0] z1, logic [11:0] z2, t_row_chk chk);
        t_dir_row row;
        row      = '{ROW_WORD, '0, '0, '0, chk};
        row.word = '{mode, x, y, z1, z2};
        return row;
    endfunction

    // drive one word and wait for its handshake
    task automatic send_word(input t_in_item w);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.data  <= w;
        do @(posedge i_clk); while (!(smp_if.valid && smp_if.ready));
        @(negedge i_clk);
        words_sent++;
    endtask

    // stop sending, let every report drain, then give the block time to go idle
    task automatic drain_and_rest();
        smp_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (REST_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        if (idx <= CFG_PENUP_TICKS)
            cfg_shadow[idx] = (idx == CFG_PENUP_TICKS) ? longint'(val) : longint'(val[11:0]);
    endtask

    // calibration limits: mostly wide and ordered, sometimes reversed or equal
    function automatic logic [23:0] cal_pair();
        logic [11:0] lo, hi;
        int          shape;
        lo    = 12'($urandom_range(0, 800));
        hi    = 12'($urandom_range(3300, 4095));
        shape = $urandom_range(0, 5);
        if (shape == 0) return {hi, lo};
        if (shape == 1) return {lo, lo};
        return {lo, hi};
    endfunction

    task automatic random_config();
        logic [23:0] xp, yp;
        xp = cal_pair();
        yp = cal_pair();
        cfg_write(CFG_CAL_X_MIN, {4'($urandom()), xp[23:12]});
        cfg_write(CFG_CAL_X_MAX, {4'($urandom()), xp[11:0]});
        cfg_write(CFG_CAL_Y_MIN, {4'($urandom()), yp[23:12]});
        cfg_write(CFG_CAL_Y_MAX, {4'($urandom()), yp[11:0]});
        cfg_write(CFG_PLATE_OHMS, {4'($urandom()), 12'($urandom_range(50, 1500))});
        cfg_write(CFG_JITTER_LIMIT, {4'($urandom()), 12'($urandom_range(6, 64))});
        cfg_write(CFG_PENUP_TICKS, 16'($urandom_range(1, 6)));
    endtask

    // one pen stroke: small moves at steady pressure, some noise, then ticks
    task automatic random_stroke();
        t_in_item w;
        longint   bx, by;
        int       len, z1, z1s, z2s, pick, ticks;
        len = $urandom_range(1, 12);
        bx  = $urandom_range(0, 4095);
        by  = $urandom_range(0, 4095);
        z1  = $urandom_range(16, 4095);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            w    = $bits(t_in_item)'({$urandom(), $urandom()});
            if (pick >= 12 && pick < 20) begin
                w.mode = MODE_TICK;
            end else if (pick >= 20) begin
                bx  = clamp_coord(bx + longint'($urandom_range(0, 6)) - 3);
                by  = clamp_coord(by + longint'($urandom_range(0, 6)) - 3);
                z1s = z1 + int'($urandom_range(0, 4));
                if (z1s > 4095) z1s = 4095;
                z2s = z1s + int'($urandom_range(0, z1s / 2));
                if (z2s > 4095) z2s = 4095;
                w.mode   = MODE_SAMPLE;
                w.raw_x  = 12'(bx);
                w.raw_y  = 12'(by);
                w.raw_z1 = 12'(z1s);
                w.raw_z2 = 12'(z2s);
            end
            send_word(w);
        end
        ticks = $urandom_range(0, int'(cfg_shadow[CFG_PENUP_TICKS]) + 2);
        repeat (ticks) begin
            w      = $bits(t_in_item)'({$urandom(), $urandom()});
            w.mode = MODE_TICK;
            send_word(w);
        end
    endtask

    // predict on every accepted word; directed rows may pin the outcome
    always @(posedge i_clk) begin
        t_out_item rpt;
        bit        hit;
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            hit = condition_sample(smp_if.data, rpt);
            if (row_check == CHK_NONE) begin
                hit = 0;
            end else if (row_check == CHK_RELEASE) begin
                hit      = 1;
                rpt      = '0;
                rpt.kind = KIND_REL;
            end
            if (hit) expected_reports.push_back(rpt);
        end
    end

    // compare each report against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && rpt_if.valid && rpt_if.ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected report: kind %0d x %0d y %0d pressure %0d start %0d",
                       rpt_if.data.kind, rpt_if.data.pos_x, rpt_if.data.pos_y,
                       rpt_if.data.pressure, rpt_if.data.touch_start);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                if (rpt_if.data.kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, rpt_if.data.kind);
                    error_count++;
                end
                if (rpt_if.data.pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, actual %0d", want.pos_x, rpt_if.data.pos_x);
                    error_count++;
                end
                if (rpt_if.data.pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, actual %0d", want.pos_y, rpt_if.data.pos_y);
                    error_count++;
                end
                if (rpt_if.data.pressure !== want.pressure) begin
                    $error("pressure: expected %0d, actual %0d",
                           want.pressure, rpt_if.data.pressure);
                    error_count++;
                end
                if (rpt_if.data.touch_start !== want.touch_start) begin
                    $error("touch_start: expected %0d, actual %0d",
                           want.touch_start, rpt_if.data.touch_start);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        rpt_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int gap_tab [3];
        int stall_tab [3];
        int goal;
        bit paused;
        bit at_rest;

        gap_tab   = '{20, 69, 0};
        stall_tab = '{69, 20, 0};

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        smp_if.valid = 1'b0;
        smp_if.data  = '0;
        rpt_if.ready = 1'b0;
        cfg_shadow   = '{0, 4095, 0, 4095, 400, 15, 100};
        prev_x       = 0;
        prev_y       = 0;
        pen_active   = 0;
        penup_count  = 0;
        penup_armed  = 0;
        row_check    = CHK_MODEL;
        src_gap_pct    = gap_tab[0];
        sink_stall_pct = stall_tab[0];
        words_sent   = 0;
        error_count  = 0;
        cycle_count  = 0;

        // defaults: identity x, inverted y
        // a tick before any sample is ignored
        dir_rows.push_back(word_row(MODE_TICK, 12'hfff, 12'hfff, 12'hfff, 12'hfff, CHK_NONE));
        // dropped: z1 zero, then z2 below z1
        dir_rows.push_back(word_row(MODE_SAMPLE, 0, 4095, 0, 4095, CHK_NONE));
        dir_rows.push_back(word_row(MODE_SAMPLE, 0, 4095, 4095, 0, CHK_NONE));
        // equal z: zero pressure
        dir_rows.push_back(word_row(MODE_SAMPLE, 0, 4095, 4095, 4095, CHK_NONE));
        // jump to the far corner: too much jitter
        dir_rows.push_back(word_row(MODE_SAMPLE, 4095, 0, 2048, 4095, CHK_NONE));
        // held still: touch start, then a plain report
        dir_rows.push_back(word_row(MODE_SAMPLE, 4095, 0, 2048, 4095, CHK_MODEL));
        dir_rows.push_back(word_row(MODE_SAMPLE, 4095, 0, 2048, 4095, CHK_MODEL));
        // pressure above range is dropped
        dir_rows.push_back(word_row(MODE_SAMPLE, 4095, 0, 1, 4095, CHK_NONE));
        // zero pen-up ticks: release on the first tick, later ticks ignored
        dir_rows.push_back(cfg_row(CFG_PENUP_TICKS, 16'h0000));
        dir_rows.push_back(word_row(MODE_SAMPLE, 4095, 0, 2048, 4095, CHK_MODEL));
        dir_rows.push_back(word_row(MODE_TICK, 0, 0, 0, 0, CHK_RELEASE));
        dir_rows.push_back(word_row(MODE_TICK, 0, 0, 0, 0, CHK_NONE));
        // equal calibration limits, zero jitter limit, longest countdown, spare index
        dir_rows.push_back(cfg_row(CFG_CAL_X_MIN, 16'hffff));
        dir_rows.push_back(cfg_row(CFG_CAL_X_MAX, 16'hffff));
        dir_rows.push_back(cfg_row(CFG_CAL_Y_MIN, 16'hf000));
        dir_rows.push_back(cfg_row(CFG_CAL_Y_MAX, 16'h0000));
        dir_rows.push_back(cfg_row(CFG_PLATE_OHMS, 16'hffff));
        dir_rows.push_back(cfg_row(CFG_JITTER_LIMIT, 16'h0000));
        dir_rows.push_back(cfg_row(CFG_PENUP_TICKS, 16'hffff));
        dir_rows.push_back(cfg_row(CFG_SPARE, 16'h5a5a));
        dir_rows.push_back(word_row(MODE_SAMPLE, 1234, 2000, 100, 200, CHK_NONE));
        dir_rows.push_back(word_row(MODE_TICK, 12'h555, 12'haaa, 12'h555, 12'haaa, CHK_NONE));
        // narrow calibration: raw extremes clamp, wide jitter limit
        dir_rows.push_back(cfg_row(CFG_CAL_X_MIN, 16'd100));
        dir_rows.push_back(cfg_row(CFG_CAL_X_MAX, 16'd4000));
        dir_rows.push_back(cfg_row(CFG_CAL_Y_MIN, 16'd100));
        dir_rows.push_back(cfg_row(CFG_CAL_Y_MAX, 16'd4000));
        dir_rows.push_back(cfg_row(CFG_PLATE_OHMS, 16'd1000));
        dir_rows.push_back(cfg_row(CFG_JITTER_LIMIT, 16'd4095));
        dir_rows.push_back(cfg_row(CFG_PENUP_TICKS, 16'd2));
        dir_rows.push_back(word_row(MODE_SAMPLE, 0, 0, 1000, 3000, CHK_MODEL));
        dir_rows.push_back(word_row(MODE_SAMPLE, 4095, 4095, 1000, 3000, CHK_MODEL));
        dir_rows.push_back(word_row(MODE_SAMPLE, 2000, 2000, 500, 4095, CHK_MODEL));
        dir_rows.push_back(word_row(MODE_TICK, 0, 0, 0, 0, CHK_NONE));
        dir_rows.push_back(word_row(MODE_TICK, 0, 0, 0, 0, CHK_RELEASE));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        at_rest = 1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                if (!at_rest) drain_and_rest();
                at_rest = 1;
                cfg_write(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                row_check = dir_rows[i].chk;
                send_word(dir_rows[i].word);
                at_rest = 0;
            end
        end
        row_check = CHK_MODEL;

        // random strokes under three idling patterns, new settings per set
        for (int ph = 0; ph < 3; ph++) begin
            src_gap_pct    = gap_tab[ph];
            sink_stall_pct = stall_tab[ph];
            for (int s = 0; s < 3; s++) begin
                drain_and_rest();
                random_config();
                goal   = words_sent + WORDS_PER_SET;
                paused = 0;
                while (words_sent < goal) begin
                    // halfway: hold off until every report is out
                    if (!paused && words_sent >= goal - WORDS_PER_SET / 2) begin
                        drain_and_rest();
                        paused = 1;
                    end
                    random_stroke();
                end
            end
        end

        drain_and_rest();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
